// ===== hw/rtl/shbe_pkg.sv =====
// Shared types, constants and constant tables of the spherical harmonic basis unit.
package shbe_pkg;

    localparam int L_MAX_DEF      = 6;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int ANGLE_PORT_W   = 16;
    localparam int CORDIC_STEPS   = 24;
    localparam int TRIG_W         = 34;
    localparam int PROD_W         = 2 * TRIG_W;
    localparam int RND_W          = PROD_W - 30;
    localparam int ACC_W          = 36;

    localparam logic signed [TRIG_W-1:0] ONE_Q30     = TRIG_W'(64'sd1073741824);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(64'sd652032874);

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_ORDER  = 2'd1;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } t_cordic_res;

    function automatic logic signed [31:0] cordic_atan(input logic [4:0] idx);
        logic signed [31:0] a;
        unique case (idx)
            5'd0:    a = 32'sh20000000;
            5'd1:    a = 32'sh12E4051E;
            5'd2:    a = 32'sh09FB385B;
            5'd3:    a = 32'sh051111D4;
            5'd4:    a = 32'sh028B0D43;
            5'd5:    a = 32'sh0145D7E1;
            5'd6:    a = 32'sh00A2F61E;
            5'd7:    a = 32'sh00517C55;
            5'd8:    a = 32'sh0028BE53;
            5'd9:    a = 32'sh00145F2F;
            5'd10:   a = 32'sh000A2F98;
            5'd11:   a = 32'sh000517CC;
            5'd12:   a = 32'sh00028BE6;
            5'd13:   a = 32'sh000145F3;
            5'd14:   a = 32'sh0000A2FA;
            5'd15:   a = 32'sh0000517D;
            5'd16:   a = 32'sh000028BE;
            5'd17:   a = 32'sh0000145F;
            5'd18:   a = 32'sh00000A30;
            5'd19:   a = 32'sh00000518;
            5'd20:   a = 32'sh0000028C;
            5'd21:   a = 32'sh00000146;
            5'd22:   a = 32'sh000000A3;
            5'd23:   a = 32'sh00000051;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

    // Coefficient of cos^n in the m-th derivative of P_l, Q15.16; octal digits are l, m, n.
    function automatic logic signed [31:0] legendre_coef(input logic [2:0] l,
                                                         input logic [2:0] m,
                                                         input logic [2:0] n);
        logic signed [31:0] c;
        unique case ({l, m, n})
            9'o000: c = 32'sd65536;
            9'o101: c = 32'sd65536;
            9'o110: c = 32'sd65536;
            9'o200: c = -32'sd32768;
            9'o202: c = 32'sd98304;
            9'o211: c = 32'sd196608;
            9'o220: c = 32'sd196608;
            9'o301: c = -32'sd98304;
            9'o303: c = 32'sd163840;
            9'o310: c = -32'sd98304;
            9'o312: c = 32'sd491520;
            9'o321: c = 32'sd983040;
            9'o330: c = 32'sd983040;
            9'o400: c = 32'sd24576;
            9'o402: c = -32'sd245760;
            9'o404: c = 32'sd286720;
            9'o411: c = -32'sd491520;
            9'o413: c = 32'sd1146880;
            9'o420: c = -32'sd491520;
            9'o422: c = 32'sd3440640;
            9'o431: c = 32'sd6881280;
            9'o440: c = 32'sd6881280;
            9'o501: c = 32'sd122880;
            9'o503: c = -32'sd573440;
            9'o505: c = 32'sd516096;
            9'o510: c = 32'sd122880;
            9'o512: c = -32'sd1720320;
            9'o514: c = 32'sd2580480;
            9'o521: c = -32'sd3440640;
            9'o523: c = 32'sd10321920;
            9'o530: c = -32'sd3440640;
            9'o532: c = 32'sd30965760;
            9'o541: c = 32'sd61931520;
            9'o550: c = 32'sd61931520;
            9'o600: c = -32'sd20480;
            9'o602: c = 32'sd430080;
            9'o604: c = -32'sd1290240;
            9'o606: c = 32'sd946176;
            9'o611: c = 32'sd860160;
            9'o613: c = -32'sd5160960;
            9'o615: c = 32'sd5677056;
            9'o620: c = 32'sd860160;
            9'o622: c = -32'sd15482880;
            9'o624: c = 32'sd28385280;
            9'o631: c = -32'sd30965760;
            9'o633: c = 32'sd113541120;
            9'o640: c = -32'sd30965760;
            9'o642: c = 32'sd340623360;
            9'o651: c = 32'sd681246720;
            9'o660: c = 32'sd681246720;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

    // Clip to the signed 32-bit range; the top bit of the result flags a clip.
    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        logic [32:0] r;
        if (v > 40'sd2147483647) begin
            r = {1'b1, 32'h7FFFFFFF};
        end else if (v < -40'sd2147483648) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/shbe_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
module shbe_cordic
    import shbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_turn,
    output t_cordic_res o_res
);

    logic signed [TRIG_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [31:0]       r_z, n_z;
    logic [4:0]               r_i, n_i;
    logic [1:0]               r_quad, n_quad;
    logic                     r_run, n_run;
    logic                     r_done, n_done;
    logic signed [TRIG_W-1:0] dx, dy;

    always_comb begin
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_i    = r_i;
        n_quad = r_quad;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = CORDIC_GAIN;
            n_y    = '0;
            n_z    = {2'b00, i_turn[29:0]};
            n_quad = i_turn[31:30];
            n_i    = '0;
            n_run  = 1'b1;
        end else if (r_run) begin
            if (!r_z[31]) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - cordic_atan(r_i);
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + cordic_atan(r_i);
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(CORDIC_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_i    <= n_i;
        r_quad <= n_quad;
    end

    // fold the first-quadrant result back to the full circle
    always_comb begin
        o_res.done = r_done;
        unique case (r_quad)
            2'd0: begin
                o_res.cos_val = r_x;
                o_res.sin_val = r_y;
            end
            2'd1: begin
                o_res.cos_val = -r_y;
                o_res.sin_val = r_x;
            end
            2'd2: begin
                o_res.cos_val = -r_x;
                o_res.sin_val = -r_y;
            end
            default: begin
                o_res.cos_val = r_y;
                o_res.sin_val = -r_x;
            end
        endcase
    end

endmodule

// ===== hw/rtl/shbe_mul.sv =====
// Shared signed multiplier with a registered product and Q30 round-half-up.
module shbe_mul
    import shbe_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [TRIG_W-1:0] i_a,
    input  logic signed [TRIG_W-1:0] i_b,
    output logic signed [RND_W-1:0]  o_rnd
);

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd536870912);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] biased;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign biased = r_prod + HALF;
    assign o_rnd  = RND_W'(biased >>> 30);

endmodule

// ===== hw/rtl/spherical_harmonic_basis_eval_unit.sv =====
// Top level of the spherical harmonic basis evaluator: sequencer, trig memory, datapath.
//
// Usage: drive a direction (polar and azimuth angle, fraction of a turn) and the batch
// flag with start high while busy is low; the request is taken at that edge and busy
// rises. The unit then streams one result per basis function on the o_ result ports,
// each marked by o_result_valid for exactly one cycle, in order m = 0..Mm, l = m..Lm,
// cos(m*phi)*P first and sin(m*phi)*P after it when m is nonzero. o_last_of_run marks
// the final result; busy falls in the cycle it is presented, so a new request may
// follow at once. Configuration writes (degree and order limit) take effect on the
// next request and are only legal while busy is low.
// Sequence: one request at a time. The polar CORDIC runs first, then each power of the
// polar sine/cosine goes through the shared multiplier, each azimuth multiple takes its
// own CORDIC pass, then each (l,m) sums its Legendre terms one at a time through the
// multiplier, with extra trig memory reads for each new m. The single shared multiplier
// and the trig memory with its one read port set the length of a request.
// Reset: the sequencer returns idle, the limits return to 6, no result is pending.
// The receiver cannot stall: results are never held back.
module spherical_harmonic_basis_eval_unit
    import shbe_pkg::*;
#(
    parameter int L_MAX      = L_MAX_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ANGLE_PORT_W-1:0] i_polar_angle,
    input  logic [ANGLE_PORT_W-1:0] i_azimuth_angle,
    input  logic                    i_final_direction,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [2:0]              i_cfg_data,
    output logic                    o_result_valid,
    output logic signed [31:0]      o_basis_value,
    output logic [5:0]              o_basis_index,
    output logic                    o_last_of_run,
    output logic                    o_batch_end,
    output logic                    o_saturated
);

    localparam int DIM = L_MAX + 1;
    localparam int JW  = $clog2(DIM);
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int WW  = 2 * TRIG_W;

    // memory banks: polar powers {sin^j, cos^j} and azimuth multiples {sin jphi, cos jphi}
    localparam logic BANK_POL = 1'b0;
    localparam logic BANK_AZ  = 1'b1;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_CTH  = 17'h00002,
        S_PS   = 17'h00004,
        S_PC   = 17'h00008,
        S_PW   = 17'h00010,
        S_AZS  = 17'h00020,
        S_CAZ  = 17'h00040,
        S_EM   = 17'h00080,
        S_EM2  = 17'h00100,
        S_EM3  = 17'h00200,
        S_EL   = 17'h00400,
        S_EN   = 17'h00800,
        S_ET1  = 17'h01000,
        S_ET2  = 17'h02000,
        S_EP   = 17'h04000,
        S_EV0  = 17'h08000,
        S_EV1  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [2:0] r_degree_limit, r_order_limit;

    // per-request control
    logic [JW-1:0] r_lm, n_lm, r_mm, n_mm;
    logic [JW-1:0] r_j, n_j, r_l, n_l, r_m, n_m, r_n, n_n;
    logic          r_fin, n_fin;
    logic [31:0]   r_phi, n_phi, r_phi_acc, n_phi_acc;
    logic [5:0]    r_k, n_k;

    // datapath
    logic signed [TRIG_W-1:0] r_s1, n_s1, r_c1, n_c1, r_ps, n_ps, r_pc, n_pc;
    logic signed [TRIG_W-1:0] r_sm, n_sm, r_azs, n_azs, r_azc, n_azc;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [31:0]              r_p, n_p;
    logic                     r_psat, n_psat;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    logic [5:0]  r_out_index, n_out_index;
    logic        r_out_last, n_out_last;
    logic        r_out_fin, n_out_fin;
    logic        r_out_sat, n_out_sat;

    // trig memory
    logic [WW-1:0] r_trig_mem [2][DIM];
    logic [WW-1:0] r_rdata;
    logic          mem_we;
    logic          mem_wbank;
    logic [JW-1:0] mem_wj;
    logic [WW-1:0] mem_wdata;
    logic          mem_rbank;
    logic [JW-1:0] mem_rj;

    // shared units
    logic                     cor_start;
    logic [31:0]              cor_turn;
    t_cordic_res              cor_res;
    logic signed [TRIG_W-1:0] mul_a, mul_b;
    logic signed [RND_W-1:0]  mul_rnd;

    // helpers
    logic          accept;
    logic [JW-1:0] lm_sel, mm_sel, d;
    logic          last_pair;
    logic [32:0]   acc_sat, val_sat;
    logic [31:0]   theta_turn, phi_turn;

    shbe_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_turn  (cor_turn),
        .o_res   (cor_res)
    );

    shbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_rnd (mul_rnd)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // widen the angles to 32-bit turn units, dropping bits above the angle width
    assign theta_turn = 32'((32'(i_polar_angle) & AMASK) << (32 - ANGLE_BITS));
    assign phi_turn   = 32'((32'(i_azimuth_angle) & AMASK) << (32 - ANGLE_BITS));

    // clamp the limits: degree to L_MAX, order to the effective degree
    assign lm_sel = (r_degree_limit > 3'(L_MAX)) ? JW'(L_MAX) : JW'(r_degree_limit);
    assign mm_sel = (JW'(r_order_limit) > lm_sel || r_order_limit > 3'(L_MAX))
                    ? lm_sel : JW'(r_order_limit);

    assign d         = r_l - r_m;
    assign last_pair = (r_l == r_lm) && (r_m == r_mm);
    assign acc_sat   = sat32(40'(r_acc));
    assign val_sat   = sat32(40'(mul_rnd));

    always_comb begin
        n_state     = r_state;
        n_lm        = r_lm;
        n_mm        = r_mm;
        n_j         = r_j;
        n_l         = r_l;
        n_m         = r_m;
        n_n         = r_n;
        n_fin       = r_fin;
        n_phi       = r_phi;
        n_phi_acc   = r_phi_acc;
        n_k         = r_k;
        n_s1        = r_s1;
        n_c1        = r_c1;
        n_ps        = r_ps;
        n_pc        = r_pc;
        n_sm        = r_sm;
        n_azs       = r_azs;
        n_azc       = r_azc;
        n_acc       = r_acc;
        n_p         = r_p;
        n_psat      = r_psat;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        n_out_fin   = r_out_fin;
        n_out_sat   = r_out_sat;
        mem_we      = 1'b0;
        mem_wbank   = BANK_POL;
        mem_wj      = '0;
        mem_wdata   = '0;
        mem_rbank   = BANK_POL;
        mem_rj      = '0;
        cor_start   = 1'b0;
        cor_turn    = r_phi_acc;
        mul_a       = r_s1;
        mul_b       = r_ps;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_lm      = lm_sel;
                    n_mm      = mm_sel;
                    n_fin     = i_final_direction;
                    n_phi     = phi_turn;
                    n_phi_acc = phi_turn;
                    n_k       = '0;
                    cor_start = 1'b1;
                    cor_turn  = theta_turn;
                    // zeroth power is exactly one
                    mem_we    = 1'b1;
                    mem_wbank = BANK_POL;
                    mem_wj    = '0;
                    mem_wdata = {ONE_Q30, ONE_Q30};
                    n_state   = S_CTH;
                end
            end
            S_CTH: begin
                mem_we = 1'b1;
                if (cor_res.done) begin
                    mem_wbank = BANK_POL;
                    mem_wj    = JW'(1);
                    mem_wdata = {cor_res.sin_val, cor_res.cos_val};
                    n_s1      = cor_res.sin_val;
                    n_ps      = cor_res.sin_val;
                    n_c1      = cor_res.cos_val;
                    n_pc      = cor_res.cos_val;
                    if (r_lm > JW'(1)) begin
                        n_j     = JW'(2);
                        n_state = S_PS;
                    end else if (r_mm != '0) begin
                        n_j     = JW'(1);
                        n_state = S_AZS;
                    end else begin
                        n_m     = '0;
                        n_state = S_EM;
                    end
                end else begin
                    // fill the zeroth azimuth multiple while the CORDIC runs
                    mem_wbank = BANK_AZ;
                    mem_wj    = '0;
                    mem_wdata = {{TRIG_W{1'b0}}, ONE_Q30};
                end
            end
            S_PS: begin
                mul_a   = r_s1;
                mul_b   = r_ps;
                n_state = S_PC;
            end
            S_PC: begin
                n_ps    = mul_rnd[TRIG_W-1:0];
                mul_a   = r_c1;
                mul_b   = r_pc;
                n_state = S_PW;
            end
            S_PW: begin
                n_pc      = mul_rnd[TRIG_W-1:0];
                mem_we    = 1'b1;
                mem_wbank = BANK_POL;
                mem_wj    = r_j;
                mem_wdata = {r_ps, mul_rnd[TRIG_W-1:0]};
                if (r_j != r_lm) begin
                    n_j     = r_j + JW'(1);
                    n_state = S_PS;
                end else if (r_mm != '0) begin
                    n_j     = JW'(1);
                    n_state = S_AZS;
                end else begin
                    n_m     = '0;
                    n_state = S_EM;
                end
            end
            S_AZS: begin
                cor_start = 1'b1;
                cor_turn  = r_phi_acc;
                n_state   = S_CAZ;
            end
            S_CAZ: begin
                if (cor_res.done) begin
                    mem_we    = 1'b1;
                    mem_wbank = BANK_AZ;
                    mem_wj    = r_j;
                    mem_wdata = {cor_res.sin_val, cor_res.cos_val};
                    if (r_j != r_mm) begin
                        n_j       = r_j + JW'(1);
                        n_phi_acc = r_phi_acc + r_phi;
                        n_state   = S_AZS;
                    end else begin
                        n_m     = '0;
                        n_state = S_EM;
                    end
                end
            end
            S_EM: begin
                mem_rbank = BANK_POL;
                mem_rj    = r_m;
                n_state   = S_EM2;
            end
            S_EM2: begin
                n_sm      = r_rdata[WW-1:TRIG_W];
                mem_rbank = BANK_AZ;
                mem_rj    = r_m;
                n_state   = S_EM3;
            end
            S_EM3: begin
                n_azs   = r_rdata[WW-1:TRIG_W];
                n_azc   = r_rdata[TRIG_W-1:0];
                n_l     = r_m;
                n_state = S_EL;
            end
            S_EL: begin
                n_acc     = '0;
                n_n       = '0;
                n_n[0]    = d[0];
                mem_rbank = BANK_POL;
                mem_rj    = n_n;
                n_state   = S_EN;
            end
            S_EN: begin
                mul_a   = TRIG_W'(legendre_coef(3'(r_l), 3'(r_m), 3'(r_n)));
                mul_b   = r_rdata[TRIG_W-1:0];
                n_state = S_ET1;
            end
            S_ET1: begin
                mul_a   = mul_rnd[TRIG_W-1:0];
                mul_b   = r_sm;
                n_state = S_ET2;
            end
            S_ET2: begin
                n_acc = r_acc + ACC_W'(mul_rnd);
                if ((JW + 1)'(r_n) + (JW + 1)'(2) <= (JW + 1)'(d)) begin
                    n_n       = r_n + JW'(2);
                    mem_rbank = BANK_POL;
                    mem_rj    = n_n;
                    n_state   = S_EN;
                end else begin
                    n_state = S_EP;
                end
            end
            S_EP: begin
                n_p     = acc_sat[31:0];
                n_psat  = acc_sat[32];
                mul_a   = TRIG_W'($signed(acc_sat[31:0]));
                mul_b   = r_azc;
                n_state = S_EV0;
            end
            S_EV0, S_EV1: begin
                n_out_valid = 1'b1;
                n_out_value = val_sat[31:0];
                n_out_sat   = r_psat | val_sat[32];
                n_out_index = r_k + 6'd1;
                n_out_fin   = r_fin;
                n_k         = r_k + 6'd1;
                mul_a       = TRIG_W'($signed(r_p));
                mul_b       = r_azs;
                if (r_state == S_EV0 && r_m != '0) begin
                    n_out_last = 1'b0;
                    n_state    = S_EV1;
                end else begin
                    // advance to the next (l, m) pair or finish
                    n_out_last = last_pair;
                    if (r_l != r_lm) begin
                        n_l     = r_l + JW'(1);
                        n_state = S_EL;
                    end else if (r_m != r_mm) begin
                        n_m     = r_m + JW'(1);
                        n_state = S_EM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_degree_limit <= 3'd6;
            r_order_limit  <= 3'd6;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEGREE: r_degree_limit <= i_cfg_data;
                    CFG_ORDER:  r_order_limit  <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
        r_lm        <= n_lm;
        r_mm        <= n_mm;
        r_j         <= n_j;
        r_l         <= n_l;
        r_m         <= n_m;
        r_n         <= n_n;
        r_fin       <= n_fin;
        r_phi       <= n_phi;
        r_phi_acc   <= n_phi_acc;
        r_k         <= n_k;
        r_s1        <= n_s1;
        r_c1        <= n_c1;
        r_ps        <= n_ps;
        r_pc        <= n_pc;
        r_sm        <= n_sm;
        r_azs       <= n_azs;
        r_azc       <= n_azc;
        r_acc       <= n_acc;
        r_p         <= n_p;
        r_psat      <= n_psat;
        r_out_value <= n_out_value;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
        r_out_fin   <= n_out_fin;
        r_out_sat   <= n_out_sat;
    end

    // trig memory with one write port and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_trig_mem[mem_wbank][mem_wj] <= mem_wdata;
        end
        r_rdata <= r_trig_mem[mem_rbank][mem_rj];
    end

    assign o_result_valid = r_out_valid;
    assign o_basis_value  = $signed(r_out_value);
    assign o_basis_index  = r_out_index;
    assign o_last_of_run  = r_out_last;
    assign o_batch_end    = r_out_fin;
    assign o_saturated    = r_out_sat;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the spherical harmonic basis unit: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
    import shbe_pkg::*;

    // Register indexes past the two real limits; writes to these must be ignored.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam int         DIM          = 7;

    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         index;
        logic               last;
        logic               batch;
        logic               sat;
    } basis_result_t;

    // Holds its own copy of the limits and the coefficient table, predicts every
    // result of a request and checks the stream coming back in order.
    class basis_scoreboard;
        basis_result_t pending_basis[$];
        longint        coef[DIM][DIM][DIM]; // [n][l][m], Q15.16
        longint        atan_turn[24];
        int            degree_lim;
        int            order_lim;
        int            mismatches;

        function new();
            longint a[24] = '{
                'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
                'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
                'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
                'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
            int l, m, n, d, lo;
            atan_turn  = a;
            degree_lim = 6;
            order_lim  = 6;
            mismatches = 0;
            foreach (coef[i, j, k]) coef[i][j][k] = 0;
            // Unnormalised Legendre coefficients from the three-term recurrence.
            coef[0][0][0] = 65536;
            coef[1][1][0] = 65536;
            for (l = 1; l < DIM; l++) coef[0][l][l] = coef[0][l-1][l-1] * (2 * l - 1);
            for (m = 0; m < DIM; m++) begin
                for (l = m + 1; l < DIM; l++) begin
                    d = l - m;
                    if (d % 2 == 0) begin
                        coef[0][l][m] = -longint'(l + m - 1) * coef[0][l-2][m] / d;
                        lo = 2;
                    end else begin
                        lo = 1;
                    end
                    if (l >= 2) begin
                        for (n = lo; n <= d; n += 2) begin
                            coef[n][l][m] = (longint'(2 * l - 1) * coef[n-1][l-1][m]
                                - longint'(l + m - 1) * (l >= 2 ? coef[n][l-2][m] : 0)) / d;
                        end
                    end
                end
            end
        endfunction

        function longint rnd30(longint v);
            return (v + (longint'(1) << 29)) >>> 30;
        endfunction

        function void rotate(logic [31:0] turn, output longint c, output longint s);
            longint x, y, z, dx, dy;
            x = 652032874;
            y = 0;
            z = longint'(turn[29:0]);
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_turn[i];
                end else begin
                    x += dx; y -= dy; z += atan_turn[i];
                end
            end
            case (turn[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void write_limit(logic [1:0] idx, logic [2:0] data);
            if (idx == CFG_DEGREE) degree_lim = data;
            else if (idx == CFG_ORDER) order_lim = data;
        endfunction

        // Predict the whole result stream of one accepted request.
        function void note_request(logic [15:0] pol, logic [15:0] az, logic fin);
            longint sp[DIM], cp[DIM], am_c[DIM], am_s[DIM];
            longint acc, t, p, v, f;
            logic [31:0] phi;
            int lm, mm, k;
            bit psat, vsat;
            basis_result_t r;
            lm = degree_lim > 6 ? 6 : degree_lim;
            mm = order_lim > lm ? lm : order_lim;
            sp[0] = longint'(1) << 30;
            cp[0] = sp[0];
            rotate({pol, 16'h0}, cp[1], sp[1]);
            for (int j = 2; j <= lm; j++) begin
                sp[j] = rnd30(sp[1] * sp[j-1]);
                cp[j] = rnd30(cp[1] * cp[j-1]);
            end
            am_c[0] = longint'(1) << 30;
            am_s[0] = 0;
            phi = {az, 16'h0};
            for (int j = 1; j <= mm; j++) rotate(phi * j, am_c[j], am_s[j]);
            k = 0;
            for (int m = 0; m <= mm; m++) begin
                for (int l = m; l <= lm; l++) begin
                    acc = 0;
                    psat = 0;
                    for (int n = (l - m) % 2; n <= l - m; n += 2) begin
                        t = rnd30(coef[n][l][m] * cp[n]);
                        acc += rnd30(t * sp[m]);
                    end
                    p = acc;
                    if (acc > 64'sd2147483647) begin p = 2147483647; psat = 1; end
                    else if (acc < -64'sd2147483648) begin p = -2147483648; psat = 1; end
                    for (int q = 0; q < (m != 0 ? 2 : 1); q++) begin
                        vsat = psat;
                        f = q ? am_s[m] : am_c[m];
                        v = rnd30(p * f);
                        if (v > 64'sd2147483647) begin v = 2147483647; vsat = 1; end
                        else if (v < -64'sd2147483648) begin v = -2147483648; vsat = 1; end
                        k++;
                        r.value = v[31:0];
                        r.index = k[5:0];
                        r.last  = 0;
                        r.batch = fin;
                        r.sat   = vsat;
                        pending_basis.push_back(r);
                    end
                end
            end
            pending_basis[pending_basis.size() - 1].last = 1;
        endfunction

        function void check_result(basis_result_t got);
            basis_result_t want;
            if (pending_basis.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d index=%0d", got.value, got.index);
                return;
            end
            want = pending_basis.pop_front();
            if (got.value !== want.value || got.index !== want.index
                    || got.last !== want.last || got.batch !== want.batch
                    || got.sat !== want.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp v=%0d k=%0d l=%b b=%b s=%b",
                              " got v=%0d k=%0d l=%b b=%b s=%b"},
                             want.value, want.index, want.last, want.batch, want.sat,
                             got.value, got.index, got.last, got.batch, got.sat);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [15:0]        i_polar_angle = 0;
    logic [15:0]        i_azimuth_angle = 0;
    logic               i_final_direction = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_index = 0;
    logic [2:0]         i_cfg_data = 0;
    logic               o_result_valid;
    logic signed [31:0] o_basis_value;
    logic [5:0]         o_basis_index;
    logic               o_last_of_run;
    logic               o_batch_end;
    logic               o_saturated;

    basis_scoreboard sb = new();

    spherical_harmonic_basis_eval_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Sample results at the edge that ends their cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result('{o_basis_value, o_basis_index, o_last_of_run,
                              o_batch_end, o_saturated});
    end

    // Present one request after an optional idle gap and hold it until taken. Start stays
    // high on return, so a back-to-back request never drops it for a step.
    task automatic send_direction(logic [15:0] pol, logic [15:0] az, logic fin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1;
        i_polar_angle     <= pol;
        i_azimuth_angle   <= az;
        i_final_direction <= fin;
        do @(posedge i_clk); while (busy);
        sb.note_request(pol, az, fin);
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (sb.pending_basis.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Write one limit, then hold the write enable low before returning.
    task automatic write_limit(logic [1:0] idx, logic [2:0] data);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_limit(idx, data);
        @(posedge i_clk);
    endtask

    // Mostly uniform angles, with quadrant edges and extremes mixed in.
    function automatic logic [15:0] pick_angle();
        logic [15:0] edges[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                  16'hC000, 16'h3FFF, 16'h0001, 16'h7FFF};
        if ($urandom_range(0, 5) == 0) return edges[$urandom_range(0, 7)];
        return 16'($urandom());
    endfunction

    initial begin
        int degs[10] = '{0, 1, 1, 7, 3, 6, 5, 2, 6, 4};
        int ords[10] = '{3, 0, 6, 7, 2, 0, 5, 7, 6, 1};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: angle extremes, quadrant boundaries, both batch flag values.
        send_direction(16'h0000, 16'h0000, 0);
        send_direction(16'hFFFF, 16'hFFFF, 1);
        send_direction(16'h4000, 16'h4000, 0);
        send_direction(16'h8000, 16'h8000, 1);
        send_direction(16'hC000, 16'hC000, 0);
        send_direction(16'h2000, 16'h6000, 0);
        send_direction(16'h0001, 16'h7FFF, 1);
        send_direction(16'hAAAA, 16'h5555, 0);
        send_direction(16'h5555, 16'hAAAA, 1);
        drain();

        // Ignored indexes, then walk the limits through the extremes and the clamps.
        write_limit(CFG_SPARE_LO, 3'($urandom()));
        write_limit(CFG_SPARE_HI, 3'($urandom()));
        send_direction(16'h1234, 16'h4321, 0);
        send_direction(16'hEDCB, 16'hBCDE, 1);
        drain();

        foreach (degs[p]) begin
            write_limit(CFG_DEGREE, 3'(degs[p]));
            write_limit(CFG_ORDER, 3'(ords[p]));
            if (p == 0) begin
                send_direction(16'hFFFF, 16'h8000, 1);
                send_direction(16'h0000, 16'hFFFF, 0);
            end
            repeat (15) send_direction(pick_angle(), pick_angle(), 1'($urandom()));
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_basis.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/shbe_pkg.sv
hw/rtl/shbe_cordic.sv
hw/rtl/shbe_mul.sv
hw/rtl/spherical_harmonic_basis_eval_unit.sv
tb/tb_top.sv
